// ===== sv/tga_truecolor_rle_decoder_assert.svh =====
// ---------------------------------------------------------------------------
// tga rle decoder assertion macros
// property wrappers shared by the decoder's assertion section
// ---------------------------------------------------------------------------
`ifndef TGA_TRUECOLOR_RLE_DECODER_ASSERT_SVH
`define TGA_TRUECOLOR_RLE_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TGARLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define TGARLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tgarle_pkg.sv =====
// ---------------------------------------------------------------------------
// tgarle_pkg
// shared types and constants of the tga true-colour rle decoder
// ---------------------------------------------------------------------------
package tgarle_pkg;

    // header layout
    localparam logic [4:0] HDR_ID_LEN = 5'd0;
    localparam logic [4:0] HDR_CMAP   = 5'd1;
    localparam logic [4:0] HDR_TYPE   = 5'd2;
    localparam logic [4:0] HDR_W_LO   = 5'd12;
    localparam logic [4:0] HDR_W_HI   = 5'd13;
    localparam logic [4:0] HDR_H_LO   = 5'd14;
    localparam logic [4:0] HDR_H_HI   = 5'd15;
    localparam logic [4:0] HDR_DEPTH  = 5'd16;
    localparam logic [4:0] HDR_DESC   = 5'd17;

    localparam logic [7:0] TYPE_RAW   = 8'd2;
    localparam logic [7:0] TYPE_RLE   = 8'd10;
    localparam logic [7:0] DEPTH_24   = 8'd24;
    localparam logic [7:0] DEPTH_32   = 8'd32;
    localparam int         ORIGIN_BIT = 5;
    localparam logic [15:0] MIN_RLE_W = 16'd4;

    // result kinds
    localparam logic KIND_RUN    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SHORT  = 3'd1;
    localparam logic [2:0] ST_CMAP   = 3'd2;
    localparam logic [2:0] ST_TYPE   = 3'd3;
    localparam logic [2:0] ST_DEPTH  = 3'd4;
    localparam logic [2:0] ST_ZERO   = 3'd5;
    localparam logic [2:0] ST_TRUNC  = 3'd6;
    localparam logic [2:0] ST_NARROW = 3'd7;

    // command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_IDSKIP,
        PH_PIXELS,
        PH_DRAIN
    } phase_t;

    // one command from the parser to the run splitter
    typedef struct packed {
        logic        has_run;
        logic        has_stat;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  count;
        logic [2:0]  status;
        logic [15:0] width;
        logic [15:0] height;
        logic        origin_top;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== sv/tgarle_if.sv =====
// ---------------------------------------------------------------------------
// tgarle interfaces
// byte input channel and pixel-run result channel, valid/ready handshake
// ---------------------------------------------------------------------------
interface tgarle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface tgarle_run_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic [7:0]  run_length;
    logic [2:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;

    modport source (output valid, output kind, output red, output green, output blue,
                    output alpha, output dest_x, output dest_y, output run_length,
                    output status, output image_width, output image_height,
                    input ready);
    modport sink   (input valid, input kind, input red, input green, input blue,
                    input alpha, input dest_x, input dest_y, input run_length,
                    input status, input image_width, input image_height,
                    output ready);
endinterface

// ===== sv/tgarle_fifo.sv =====
// ---------------------------------------------------------------------------
// tgarle_fifo
// small command queue between the byte parser and the run splitter
// ---------------------------------------------------------------------------
module tgarle_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tgarle_pkg::cmd_t    push_cmd,
    input  logic                pop,
    output tgarle_pkg::cmd_t    head,
    output tgarle_pkg::q_stat_t stat
);

    tgarle_pkg::cmd_t                    mem [tgarle_pkg::QUEUE_DEPTH];
    logic [tgarle_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [tgarle_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [tgarle_pkg::QUEUE_CW-1:0]     count_reg;
    logic [tgarle_pkg::QUEUE_CW-1:0]     count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == tgarle_pkg::QUEUE_CW'(tgarle_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ===== sv/tgarle_front.sv =====
// ---------------------------------------------------------------------------
// tgarle_front
// byte parser: header, id skip, pixel assembly and rle packets into commands
// ---------------------------------------------------------------------------
module tgarle_front
(
    input  logic                clk,
    input  logic                rst_n,
    tgarle_byte_if.sink         file_bytes,
    input  tgarle_pkg::q_stat_t q_stat,
    output logic                q_push,
    output tgarle_pkg::cmd_t    q_cmd
);

    tgarle_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]  id_left_reg, id_left_next;
    logic        rle_reg, rle_next;
    logic        alpha_reg, alpha_next;
    logic        origin_reg, origin_next;
    logic [15:0] image_w_reg, image_w_next;
    logic [15:0] image_h_reg, image_h_next;
    logic [2:0]  reject_reg, reject_next;
    logic [7:0]  pkt_left_reg, pkt_left_next;
    logic        pkt_rep_reg, pkt_rep_next;
    logic [1:0]  bip_reg, bip_next;
    logic [23:0] held_reg, held_next;
    logic [31:0] remain_reg, remain_next;

    logic        accept;
    logic [7:0]  b;
    logic [1:0]  bip_last;
    logic [7:0]  count;
    logic [7:0]  emitted;
    logic [31:0] area;
    logic        run_out;

    assign accept          = file_bytes.valid && file_bytes.ready;
    assign file_bytes.ready = !q_stat.full;
    assign b               = file_bytes.data_byte;
    assign bip_last        = alpha_reg ? 2'd3 : 2'd2;
    assign area            = image_w_reg * image_h_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_idx_next  = hdr_idx_reg;
        id_left_next  = id_left_reg;
        rle_next      = rle_reg;
        alpha_next    = alpha_reg;
        origin_next   = origin_reg;
        image_w_next  = image_w_reg;
        image_h_next  = image_h_reg;
        reject_next   = reject_reg;
        pkt_left_next = pkt_left_reg;
        pkt_rep_next  = pkt_rep_reg;
        bip_next      = bip_reg;
        held_next     = held_reg;
        remain_next   = remain_reg;
        count         = 8'd1;
        emitted       = 8'd0;
        run_out       = 1'b0;

        q_cmd            = '0;
        q_cmd.alpha      = alpha_reg ? b : 8'hFF;
        q_cmd.red        = alpha_reg ? held_reg[23:16] : b;
        q_cmd.green      = held_reg[15:8];
        q_cmd.blue       = held_reg[7:0];
        q_cmd.origin_top = origin_reg;

        case (phase_reg)
            tgarle_pkg::PH_HEADER:
            begin
                case (hdr_idx_reg)
                    tgarle_pkg::HDR_ID_LEN: id_left_next = b;
                    tgarle_pkg::HDR_CMAP:
                    begin
                        if (b != 8'd0 && reject_reg == tgarle_pkg::ST_OK)
                        begin
                            reject_next = tgarle_pkg::ST_CMAP;
                        end
                    end
                    tgarle_pkg::HDR_TYPE:
                    begin
                        rle_next = (b == tgarle_pkg::TYPE_RLE);
                        if (b != tgarle_pkg::TYPE_RAW && b != tgarle_pkg::TYPE_RLE
                            && reject_reg == tgarle_pkg::ST_OK)
                        begin
                            reject_next = tgarle_pkg::ST_TYPE;
                        end
                    end
                    tgarle_pkg::HDR_W_LO: image_w_next = {8'd0, b};
                    tgarle_pkg::HDR_W_HI: image_w_next = {b, image_w_reg[7:0]};
                    tgarle_pkg::HDR_H_LO: image_h_next = {8'd0, b};
                    tgarle_pkg::HDR_H_HI: image_h_next = {b, image_h_reg[7:0]};
                    tgarle_pkg::HDR_DEPTH:
                    begin
                        alpha_next = (b == tgarle_pkg::DEPTH_32);
                        if (b != tgarle_pkg::DEPTH_24 && b != tgarle_pkg::DEPTH_32
                            && reject_reg == tgarle_pkg::ST_OK)
                        begin
                            reject_next = tgarle_pkg::ST_DEPTH;
                        end
                    end
                    tgarle_pkg::HDR_DESC:
                    begin
                        origin_next = b[tgarle_pkg::ORIGIN_BIT];
                        if (reject_reg == tgarle_pkg::ST_OK)
                        begin
                            if (image_w_reg == 16'd0 || image_h_reg == 16'd0)
                            begin
                                reject_next = tgarle_pkg::ST_ZERO;
                            end
                            else if (rle_reg && image_w_reg < tgarle_pkg::MIN_RLE_W)
                            begin
                                reject_next = tgarle_pkg::ST_NARROW;
                            end
                        end
                    end
                    default: ;
                endcase

                if (hdr_idx_reg != tgarle_pkg::HDR_DESC)
                begin
                    hdr_idx_next = hdr_idx_reg + 5'd1;
                end
                else if (reject_next != tgarle_pkg::ST_OK)
                begin
                    phase_next = tgarle_pkg::PH_DRAIN;
                end
                else
                begin
                    remain_next = area;
                    phase_next  = (id_left_reg != 8'd0) ? tgarle_pkg::PH_IDSKIP
                                                         : tgarle_pkg::PH_PIXELS;
                end
            end

            tgarle_pkg::PH_IDSKIP:
            begin
                id_left_next = id_left_reg - 8'd1;
                if (id_left_reg == 8'd1)
                begin
                    phase_next = tgarle_pkg::PH_PIXELS;
                end
            end

            tgarle_pkg::PH_PIXELS:
            begin
                if (rle_reg && pkt_left_reg == 8'd0)
                begin
                    // packet header
                    pkt_left_next = {1'b0, b[6:0]} + 8'd1;
                    pkt_rep_next  = b[7];
                    bip_next      = 2'd0;
                end
                else if (bip_reg != bip_last)
                begin
                    case (bip_reg)
                        2'd0: held_next[7:0]   = b;
                        2'd1: held_next[15:8]  = b;
                        2'd2: held_next[23:16] = b;
                        default: ;
                    endcase
                    bip_next = bip_reg + 2'd1;
                end
                else
                begin
                    // pixel complete
                    bip_next = 2'd0;
                    if (rle_reg && pkt_rep_reg)
                    begin
                        count         = pkt_left_reg;
                        pkt_left_next = 8'd0;
                    end
                    else if (rle_reg)
                    begin
                        pkt_left_next = pkt_left_reg - 8'd1;
                    end
                    emitted     = (remain_reg < {24'd0, count}) ? remain_reg[7:0] : count;
                    remain_next = remain_reg - {24'd0, emitted};
                    run_out     = 1'b1;
                    if (remain_next == 32'd0)
                    begin
                        phase_next = tgarle_pkg::PH_DRAIN;
                    end
                end
            end

            default: ;
        endcase

        q_cmd.has_run = run_out;
        q_cmd.count   = emitted;
        q_cmd.width   = image_w_next;
        q_cmd.height  = image_h_next;

        if (file_bytes.last)
        begin
            q_cmd.has_stat = 1'b1;
            if (phase_next == tgarle_pkg::PH_HEADER)
            begin
                q_cmd.status = tgarle_pkg::ST_SHORT;
            end
            else if (phase_next == tgarle_pkg::PH_DRAIN)
            begin
                q_cmd.status = reject_next;
            end
            else
            begin
                q_cmd.status = tgarle_pkg::ST_TRUNC;
            end

            // back to the reset state for the next file
            phase_next    = tgarle_pkg::PH_HEADER;
            hdr_idx_next  = '0;
            id_left_next  = '0;
            rle_next      = 1'b0;
            alpha_next    = 1'b0;
            origin_next   = 1'b0;
            image_w_next  = '0;
            image_h_next  = '0;
            reject_next   = tgarle_pkg::ST_OK;
            pkt_left_next = '0;
            pkt_rep_next  = 1'b0;
            bip_next      = '0;
            held_next     = '0;
            remain_next   = '0;
        end
    end

    assign q_push = accept && (run_out || file_bytes.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tgarle_pkg::PH_HEADER;
            hdr_idx_reg  <= '0;
            id_left_reg  <= '0;
            rle_reg      <= 1'b0;
            alpha_reg    <= 1'b0;
            origin_reg   <= 1'b0;
            image_w_reg  <= '0;
            image_h_reg  <= '0;
            reject_reg   <= tgarle_pkg::ST_OK;
            pkt_left_reg <= '0;
            pkt_rep_reg  <= 1'b0;
            bip_reg      <= '0;
            held_reg     <= '0;
            remain_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            hdr_idx_reg  <= hdr_idx_next;
            id_left_reg  <= id_left_next;
            rle_reg      <= rle_next;
            alpha_reg    <= alpha_next;
            origin_reg   <= origin_next;
            image_w_reg  <= image_w_next;
            image_h_reg  <= image_h_next;
            reject_reg   <= reject_next;
            pkt_left_reg <= pkt_left_next;
            pkt_rep_reg  <= pkt_rep_next;
            bip_reg      <= bip_next;
            held_reg     <= held_next;
            remain_reg   <= remain_next;
        end
    end

endmodule

// ===== sv/tgarle_back.sv =====
// ---------------------------------------------------------------------------
// tgarle_back
// run splitter: cuts runs at row ends, flips rows, drives the result register
// ---------------------------------------------------------------------------
module tgarle_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  tgarle_pkg::cmd_t    head,
    input  tgarle_pkg::q_stat_t q_stat,
    output logic                q_pop,
    tgarle_run_if.source        pixel_runs
);

    logic        started_reg;
    logic [7:0]  left_reg;
    logic        run_done_reg;
    logic [15:0] col_reg;
    logic [15:0] row_reg;

    logic        out_valid_reg;
    logic        kind_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg;
    logic [15:0] dest_x_reg, dest_y_reg;
    logic [7:0]  len_reg;
    logic [2:0]  status_reg;
    logic [15:0] width_reg, height_reg;

    logic        advance;
    logic        fire;
    logic        do_run;
    logic [7:0]  left;
    logic [15:0] space;
    logic [7:0]  seg;
    logic [16:0] col_sum;
    logic [7:0]  left_after;
    logic [15:0] dest_y;
    logic        stat_ok;

    assign advance    = !out_valid_reg || pixel_runs.ready;
    assign fire       = advance && !q_stat.empty;
    assign do_run     = head.has_run && !run_done_reg;
    assign left       = started_reg ? left_reg : head.count;
    assign space      = head.width - col_reg;
    assign seg        = (space < {8'd0, left}) ? space[7:0] : left;
    assign col_sum    = {1'b0, col_reg} + {9'd0, seg};
    assign left_after = left - seg;
    assign dest_y     = head.origin_top ? row_reg : (head.height - 16'd1 - row_reg);
    assign stat_ok    = (head.status == tgarle_pkg::ST_OK);

    assign q_pop = fire && (!do_run || (left_after == 8'd0 && !head.has_stat));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            left_reg      <= '0;
            run_done_reg  <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= !q_stat.empty;
            end
            if (fire)
            begin
                if (do_run)
                begin
                    if (col_sum >= {1'b0, head.width})
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + 16'd1;
                    end
                    else
                    begin
                        col_reg <= col_sum[15:0];
                    end
                    if (left_after == 8'd0)
                    begin
                        started_reg  <= 1'b0;
                        run_done_reg <= head.has_stat;
                    end
                    else
                    begin
                        started_reg <= 1'b1;
                        left_reg    <= left_after;
                    end
                end
                else
                begin
                    col_reg      <= '0;
                    row_reg      <= '0;
                    run_done_reg <= 1'b0;
                    started_reg  <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (do_run)
            begin
                kind_reg   <= tgarle_pkg::KIND_RUN;
                red_reg    <= head.red;
                green_reg  <= head.green;
                blue_reg   <= head.blue;
                alpha_reg  <= head.alpha;
                dest_x_reg <= col_reg;
                dest_y_reg <= dest_y;
                len_reg    <= seg;
                status_reg <= tgarle_pkg::ST_OK;
                width_reg  <= '0;
                height_reg <= '0;
            end
            else
            begin
                kind_reg   <= tgarle_pkg::KIND_STATUS;
                red_reg    <= '0;
                green_reg  <= '0;
                blue_reg   <= '0;
                alpha_reg  <= '0;
                dest_x_reg <= '0;
                dest_y_reg <= '0;
                len_reg    <= '0;
                status_reg <= head.status;
                width_reg  <= stat_ok ? head.width : 16'd0;
                height_reg <= stat_ok ? head.height : 16'd0;
            end
        end
    end

    assign pixel_runs.valid        = out_valid_reg;
    assign pixel_runs.kind         = kind_reg;
    assign pixel_runs.red          = red_reg;
    assign pixel_runs.green        = green_reg;
    assign pixel_runs.blue         = blue_reg;
    assign pixel_runs.alpha        = alpha_reg;
    assign pixel_runs.dest_x       = dest_x_reg;
    assign pixel_runs.dest_y       = dest_y_reg;
    assign pixel_runs.run_length   = len_reg;
    assign pixel_runs.status       = status_reg;
    assign pixel_runs.image_width  = width_reg;
    assign pixel_runs.image_height = height_reg;

endmodule

// ===== sv/tga_truecolor_rle_decoder.sv =====
// a byte that finishes a pixel is written into the command queue, and its first run is then
//   loaded from the queue head into the result register once that register is free
// throughput: one file byte per cycle while the command queue is not full; a run crossing k
//   destination rows becomes k result beats in the run splitter, and the four-entry command queue absorbs that
// reset: rst_n asynchronous, active low; clears parser, queue and result valid
// after the byte marked last the decoder is back in its reset state for the next file
// ---------------------------------------------------------------------------
// tga_truecolor_rle_decoder
// decodes a tga true-colour file, raw or rle, into rgba pixel runs per row
// ---------------------------------------------------------------------------
module tga_truecolor_rle_decoder
(
    input  logic         clk,
    input  logic         rst_n,
    tgarle_byte_if.sink  file_bytes,
    tgarle_run_if.source pixel_runs
);

    // commands cross from the parser to the splitter through the queue
    logic                q_push;
    logic                q_pop;
    tgarle_pkg::cmd_t    q_cmd;
    tgarle_pkg::cmd_t    q_head;
    tgarle_pkg::q_stat_t q_stat;

    // front: header parse, id skip, bgr(a) assembly, rle packet tracking;
    // it also counts pixels left so it knows when trailing bytes start
    tgarle_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .file_bytes (file_bytes),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    // queue: lets byte intake carry on while a long run is split over rows
    tgarle_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    // back: column and row tracking, row flip, result register
    tgarle_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .q_stat     (q_stat),
        .q_pop      (q_pop),
        .pixel_runs (pixel_runs)
    );

`include "tga_truecolor_rle_decoder_assert.svh"

    // a pixel run beat always carries pixels and a clean status
    `TGARLE_ASSERT_NOW(a_run_nonempty, pixel_runs.valid && pixel_runs.kind == tgarle_pkg::KIND_RUN, pixel_runs.run_length != 8'd0 && pixel_runs.status == tgarle_pkg::ST_OK, "empty pixel run")

    // queue never written while full
    `TGARLE_ASSERT_NOW(a_no_overflow, q_push, !q_stat.full, "command queue overflow")

    // splitter never pops an empty queue
    `TGARLE_ASSERT_NOW(a_no_underflow, q_pop, !q_stat.empty, "command queue underflow")

    // a full queue with no pop stays closed to the parser
    `TGARLE_ASSERT_NEXT(a_full_holds, q_stat.full && !q_pop, !q_push, "push into held-full queue")

endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// streams generated tga files into the decoder one byte per beat and
// checks every run and status beat against a cycle-free predictor
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // one beat of the result channel, field by field
    typedef struct packed {
        logic        kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] dest_x;
        logic [15:0] dest_y;
        logic [7:0]  run_length;
        logic [2:0]  status;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } run_beat_t;

    // predicts the decoder from the byte stream and holds the runs still owed
    class run_scoreboard;
        run_beat_t   expected_runs[$];
        int unsigned error_count;

        logic [4:0]  header_index;
        logic [7:0]  id_left;
        tgarle_pkg::phase_t phase;
        logic        rle_mode;
        logic        alpha_present;
        logic        origin_top;
        logic [15:0] image_w;
        logic [15:0] image_h;
        logic [2:0]  reject_code;
        logic [7:0]  packet_left;
        logic        packet_repeats;
        logic [1:0]  byte_in_pixel;
        logic [31:0] held_color;
        logic [15:0] file_column;
        logic [15:0] file_row;
        logic [31:0] pixels_remaining;

        function new();
            error_count = 0;
            clear_state();
        endfunction

        function void clear_state();
            header_index     = '0;
            id_left          = '0;
            phase            = tgarle_pkg::PH_HEADER;
            rle_mode         = 1'b0;
            alpha_present    = 1'b0;
            origin_top       = 1'b0;
            image_w          = '0;
            image_h          = '0;
            reject_code      = tgarle_pkg::ST_OK;
            packet_left      = '0;
            packet_repeats   = 1'b0;
            byte_in_pixel    = '0;
            held_color       = '0;
            file_column      = '0;
            file_row         = '0;
            pixels_remaining = '0;
        endfunction

        // first fault wins
        function void note_fault(logic [2:0] code);
            if (reject_code == tgarle_pkg::ST_OK)
                reject_code = code;
        endfunction

        // split count copies of the held pixel at row ends
        function void emit_pixels(int unsigned count);
            run_beat_t   beat;
            int unsigned seg;
            beat = '0;
            beat.kind  = tgarle_pkg::KIND_RUN;
            beat.blue  = held_color[7:0];
            beat.green = held_color[15:8];
            beat.red   = held_color[23:16];
            beat.alpha = alpha_present ? held_color[31:24] : 8'hFF;
            while (count > 0 && pixels_remaining > 0 && file_column < image_w)
            begin
                seg = 32'(image_w) - 32'(file_column);
                if (seg > count)
                    seg = count;
                if (seg > pixels_remaining)
                    seg = pixels_remaining;
                beat.dest_x     = file_column;
                beat.dest_y     = origin_top ? file_row : image_h - 16'd1 - file_row;
                beat.run_length = seg[7:0];
                expected_runs.push_back(beat);
                file_column += seg[15:0];
                if (file_column >= image_w)
                begin
                    file_column = '0;
                    file_row++;
                end
                pixels_remaining -= seg;
                count -= seg;
            end
            if (pixels_remaining == 0)
                phase = tgarle_pkg::PH_DRAIN;
        endfunction

        function void decode_header_byte(logic [7:0] b);
            case (header_index)
                tgarle_pkg::HDR_ID_LEN: id_left = b;
                tgarle_pkg::HDR_CMAP:
                    if (b != 8'd0) note_fault(tgarle_pkg::ST_CMAP);
                tgarle_pkg::HDR_TYPE:
                begin
                    rle_mode = (b == tgarle_pkg::TYPE_RLE);
                    if (b != tgarle_pkg::TYPE_RAW && b != tgarle_pkg::TYPE_RLE)
                        note_fault(tgarle_pkg::ST_TYPE);
                end
                tgarle_pkg::HDR_W_LO: image_w = {8'h00, b};
                tgarle_pkg::HDR_W_HI: image_w[15:8] = b;
                tgarle_pkg::HDR_H_LO: image_h = {8'h00, b};
                tgarle_pkg::HDR_H_HI: image_h[15:8] = b;
                tgarle_pkg::HDR_DEPTH:
                begin
                    alpha_present = (b == tgarle_pkg::DEPTH_32);
                    if (b != tgarle_pkg::DEPTH_24 && b != tgarle_pkg::DEPTH_32)
                        note_fault(tgarle_pkg::ST_DEPTH);
                end
                tgarle_pkg::HDR_DESC:
                begin
                    origin_top = b[tgarle_pkg::ORIGIN_BIT];
                    if (image_w == 0 || image_h == 0)
                        note_fault(tgarle_pkg::ST_ZERO);
                    else if (rle_mode && image_w < tgarle_pkg::MIN_RLE_W)
                        note_fault(tgarle_pkg::ST_NARROW);
                end
                default: ;
            endcase
            if (header_index < tgarle_pkg::HDR_DESC)
            begin
                header_index++;
                return;
            end
            if (reject_code != tgarle_pkg::ST_OK)
            begin
                phase = tgarle_pkg::PH_DRAIN;
                return;
            end
            pixels_remaining = {16'h0000, image_w} * {16'h0000, image_h};
            file_column = '0;
            file_row    = '0;
            phase = (id_left != 0) ? tgarle_pkg::PH_IDSKIP : tgarle_pkg::PH_PIXELS;
        endfunction

        function void decode_pixel_byte(logic [7:0] b);
            int unsigned bpp;
            bpp = alpha_present ? 4 : 3;
            if (rle_mode && packet_left == 0)
            begin
                packet_left    = {1'b0, b[6:0]} + 8'd1;
                packet_repeats = b[7];
                byte_in_pixel  = '0;
                return;
            end
            if (byte_in_pixel == 0)
                held_color = {24'h000000, b};
            else
                held_color |= {24'h000000, b} << (8 * byte_in_pixel);
            if (byte_in_pixel + 1 < bpp)
            begin
                byte_in_pixel++;
                return;
            end
            byte_in_pixel = '0;
            if (!rle_mode)
                emit_pixels(1);
            else if (packet_repeats)
            begin
                emit_pixels(32'(packet_left));
                packet_left = '0;
            end
            else
            begin
                emit_pixels(1);
                packet_left--;
            end
        endfunction

        // called for every accepted input beat
        function void note_byte(logic [7:0] b, logic is_last);
            run_beat_t  beat;
            logic [2:0] st;
            case (phase)
                tgarle_pkg::PH_HEADER: decode_header_byte(b);
                tgarle_pkg::PH_IDSKIP:
                begin
                    if (id_left != 0)
                        id_left--;
                    if (id_left == 0)
                        phase = tgarle_pkg::PH_PIXELS;
                end
                tgarle_pkg::PH_PIXELS: decode_pixel_byte(b);
                default: ;
            endcase
            if (is_last)
            begin
                if (phase == tgarle_pkg::PH_HEADER)
                    st = tgarle_pkg::ST_SHORT;
                else if (phase == tgarle_pkg::PH_DRAIN)
                    st = reject_code;
                else
                    st = tgarle_pkg::ST_TRUNC;
                beat = '0;
                beat.kind   = tgarle_pkg::KIND_STATUS;
                beat.status = st;
                if (st == tgarle_pkg::ST_OK)
                begin
                    beat.image_width  = image_w;
                    beat.image_height = image_h;
                end
                expected_runs.push_back(beat);
                clear_state();
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned seen);
            if (want != seen)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, want, seen);
                error_count++;
            end
        endfunction

        // called for every accepted result beat
        function void check_run(run_beat_t seen);
            run_beat_t want;
            if (expected_runs.size() == 0)
            begin
                $error("result beat with nothing expected: kind %0d status %0d",
                       seen.kind, seen.status);
                error_count++;
                return;
            end
            want = expected_runs.pop_front();
            compare_field("kind", 32'(want.kind), 32'(seen.kind));
            compare_field("red", 32'(want.red), 32'(seen.red));
            compare_field("green", 32'(want.green), 32'(seen.green));
            compare_field("blue", 32'(want.blue), 32'(seen.blue));
            compare_field("alpha", 32'(want.alpha), 32'(seen.alpha));
            compare_field("dest_x", 32'(want.dest_x), 32'(seen.dest_x));
            compare_field("dest_y", 32'(want.dest_y), 32'(seen.dest_y));
            compare_field("run_length", 32'(want.run_length), 32'(seen.run_length));
            compare_field("status", 32'(want.status), 32'(seen.status));
            compare_field("image_width", 32'(want.image_width), 32'(seen.image_width));
            compare_field("image_height", 32'(want.image_height),
                          32'(seen.image_height));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tgarle_byte_if byte_ch();
    tgarle_run_if  run_ch();

    tga_truecolor_rle_decoder dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .file_bytes (byte_ch),
        .pixel_runs (run_ch)
    );

    run_scoreboard sb = new();

    logic [7:0]  tga_file[$];   // bytes of the file about to be sent
    int unsigned bytes_sent;
    bit          calm;          // set for the closing stretch: no idling either side
    int unsigned stall_left;
    run_beat_t   seen_beat;

    // 10 ns clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // hard limit on the whole run
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: ready drops in random bursts, changed on the falling edge
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            run_ch.ready <= 1'b0;
        end
        else if (!calm && rst_n && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            run_ch.ready <= 1'b0;
        end
        else
            run_ch.ready <= 1'b1;
    end

    // result beats are taken on the rising edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n && run_ch.valid && run_ch.ready)
        begin
            seen_beat = '{run_ch.kind, run_ch.red, run_ch.green, run_ch.blue,
                          run_ch.alpha, run_ch.dest_x, run_ch.dest_y,
                          run_ch.run_length, run_ch.status, run_ch.image_width,
                          run_ch.image_height};
            sb.check_run(seen_beat);
        end
    end

    // all driving tasks start and end on a falling edge

    // one byte beat; waits for the handshake, then lets the predictor see it
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= value;
        byte_ch.last      <= is_last;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        sb.note_byte(value, is_last);
        bytes_sent++;
        @(negedge clk);
    endtask

    // sender gap; valid is held low while the task waits
    task automatic idle_sender(input int unsigned cycles);
        byte_ch.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // hold the byte stream until every owed result has come back
    task automatic wait_for_drain();
        byte_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.expected_runs.size() != 0);
    endtask

    // whole file, last flag on its final byte, random gaps in between
    task automatic send_file();
        for (int i = 0; i < tga_file.size(); i++)
        begin
            calm = (bytes_sent >= 250);
            send_byte(tga_file[i], i == tga_file.size() - 1);
            if (!calm && $urandom_range(0, 5) == 0)
                idle_sender($urandom_range(1, 7));
        end
    endtask

    // 18 header bytes plus the id field; colour-map spec and origin fields are noise
    task automatic put_header(input logic [7:0] id_len, input logic [7:0] cmap,
                              input logic [7:0] ftype, input logic [15:0] w,
                              input logic [15:0] h, input logic [7:0] depth,
                              input logic [7:0] desc);
        tga_file.push_back(id_len);
        tga_file.push_back(cmap);
        tga_file.push_back(ftype);
        repeat (9) tga_file.push_back(8'($urandom_range(0, 255)));
        tga_file.push_back(w[7:0]);
        tga_file.push_back(w[15:8]);
        tga_file.push_back(h[7:0]);
        tga_file.push_back(h[15:8]);
        tga_file.push_back(depth);
        tga_file.push_back(desc);
        repeat (id_len) tga_file.push_back(8'($urandom_range(0, 255)));
    endtask

    // pixel data for total pixels; rle mixes repeat and literal packets, some
    // repeats long enough to wrap several rows or overrun the image
    task automatic put_pixels(input logic rle, input int unsigned bpp,
                              input int unsigned total);
        int unsigned left;
        int unsigned n;
        logic        rep;
        left = total;
        while (left > 0)
        begin
            if (!rle)
            begin
                repeat (bpp) tga_file.push_back(8'($urandom_range(0, 255)));
                left--;
            end
            else
            begin
                rep = 1'($urandom_range(0, 1));
                if (rep)
                begin
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128)
                                                    : $urandom_range(1, 8);
                    tga_file.push_back(8'h80 | 8'(n - 1));
                    repeat (bpp) tga_file.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    n = $urandom_range(1, 4);
                    tga_file.push_back(8'(n - 1));
                    repeat (n * bpp) tga_file.push_back(8'($urandom_range(0, 255)));
                end
                left = (n >= left) ? 0 : left - n;
            end
        end
    endtask

    // well-formed small image, optionally cut short somewhere after the header
    task automatic build_image(input logic rle, input bit cut_short);
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  depth;
        logic [7:0]  id_len;
        int unsigned keep;
        depth  = $urandom_range(0, 1) ? tgarle_pkg::DEPTH_32 : tgarle_pkg::DEPTH_24;
        w      = rle ? 16'($urandom_range(4, 8)) : 16'($urandom_range(1, 5));
        h      = 16'($urandom_range(1, 3));
        id_len = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 3)) : 8'd0;
        put_header(id_len, 8'h00, rle ? tgarle_pkg::TYPE_RLE : tgarle_pkg::TYPE_RAW,
                   w, h, depth, 8'($urandom_range(0, 255)));
        put_pixels(rle, (depth == tgarle_pkg::DEPTH_32) ? 4 : 3, 32'(w) * 32'(h));
        if (cut_short)
        begin
            keep = $urandom_range(18, tga_file.size() - 1);
            while (tga_file.size() > keep)
                void'(tga_file.pop_back());
        end
        else
            repeat ($urandom_range(0, 2)) tga_file.push_back(8'($urandom_range(0, 255)));
    endtask

    // header with one or more faults at once, then a few ignored bytes
    task automatic build_faulty_header();
        logic [4:0]  faults;
        logic [7:0]  cmap;
        logic [7:0]  ftype;
        logic [7:0]  depth;
        logic [15:0] w;
        logic [15:0] h;
        faults = 5'($urandom_range(1, 31));
        cmap   = faults[0] ? 8'($urandom_range(1, 255)) : 8'h00;
        if (faults[1])
            do
                ftype = 8'($urandom_range(0, 255));
            while (ftype == tgarle_pkg::TYPE_RAW || ftype == tgarle_pkg::TYPE_RLE);
        else if (faults[4])
            ftype = tgarle_pkg::TYPE_RLE;
        else
            ftype = $urandom_range(0, 1) ? tgarle_pkg::TYPE_RLE : tgarle_pkg::TYPE_RAW;
        if (faults[2])
            do
                depth = 8'($urandom_range(0, 255));
            while (depth == tgarle_pkg::DEPTH_24 || depth == tgarle_pkg::DEPTH_32);
        else
            depth = $urandom_range(0, 1) ? tgarle_pkg::DEPTH_32 : tgarle_pkg::DEPTH_24;
        w = faults[4] ? 16'($urandom_range(1, 3)) : 16'($urandom_range(4, 8));
        h = 16'($urandom_range(1, 3));
        if (faults[3])
            case ($urandom_range(0, 2))
                0:       w = '0;
                1:       h = '0;
                default:
                begin
                    w = '0;
                    h = '0;
                end
            endcase
        put_header(8'($urandom_range(0, 2)), cmap, ftype, w, h, depth,
                   8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 4)) tga_file.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_random_file(input int unsigned pick);
        logic rle;
        logic [7:0] depth;
        rle = 1'($urandom_range(0, 1));
        case (pick)
            0: build_image(1'b0, 1'b0);
            1: build_image(1'b1, 1'b0);
            2:
            begin
                // header cut before its final byte
                build_image(rle, 1'b0);
                while (tga_file.size() > 17)
                    void'(tga_file.pop_back());
                while (tga_file.size() > $urandom_range(1, 17))
                    void'(tga_file.pop_back());
            end
            3: build_faulty_header();
            4: build_image(rle, 1'b1);
            5:
            begin
                // largest size the header can give, ended after a few pixels
                depth = $urandom_range(0, 1) ? tgarle_pkg::DEPTH_32 : tgarle_pkg::DEPTH_24;
                put_header(8'h00, 8'h00,
                           rle ? tgarle_pkg::TYPE_RLE : tgarle_pkg::TYPE_RAW, 16'hFFFF,
                           16'hFFFF, depth, 8'($urandom_range(0, 255)));
                put_pixels(rle, (depth == tgarle_pkg::DEPTH_32) ? 4 : 3,
                           $urandom_range(1, 4));
            end
            default:
                repeat ($urandom_range(18, 24))
                    tga_file.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    initial
    begin
        int unsigned file_no;
        // every input known from time zero, reset held low before release
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.last      = 1'b0;
        run_ch.ready      = 1'b0;
        bytes_sent        = 0;
        calm              = 1'b0;
        stall_left        = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: a one-byte file, all data bits high, ends on header byte 0
        tga_file = {8'hFF};
        send_file();

        // directed: narrowest rle image, top-left origin, one repeat packet
        // of 128 that must be cut at the fourth pixel
        tga_file.delete();
        put_header(8'h00, 8'h00, tgarle_pkg::TYPE_RLE, 16'd4, 16'd1, tgarle_pkg::DEPTH_24,
                   8'h20);
        tga_file.push_back(8'hFF);
        tga_file.push_back(8'h00);
        tga_file.push_back(8'h80);
        tga_file.push_back(8'hFF);
        send_file();

        // random files: two passes through every kind, then any mix
        file_no = 0;
        while (bytes_sent < 320)
        begin
            tga_file.delete();
            build_random_file((file_no < 14) ? file_no % 7 : $urandom_range(0, 6));
            if (file_no == 2 || (!calm && $urandom_range(0, 5) == 0))
                wait_for_drain();
            send_file();
            file_no++;
        end
        byte_ch.valid <= 1'b0;

        // everything owed must come back, then a short quiet spell for strays
        while (sb.expected_runs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/tgarle_pkg.sv
sv/tgarle_if.sv
sv/tgarle_fifo.sv
sv/tgarle_front.sv
sv/tgarle_back.sv
sv/tga_truecolor_rle_decoder.sv
test/testbench.sv
